// ===== design/overtake_assist_headway_controller_assert.svh =====
// Assertion macros for the overtake assist headway controller modules.
`ifndef OVERTAKE_ASSIST_HEADWAY_CONTROLLER_ASSERT_SVH
`define OVERTAKE_ASSIST_HEADWAY_CONTROLLER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OAHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define OAHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/oahc_pkg.sv =====
// Types, codes and constants of the overtake assist headway controller.
package oahc_pkg;

  localparam int unsigned IN_W       = 72;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HYST = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_LIMIT  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_HYST   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_THR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_IV    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 4'd7;

  // Register reset values
  localparam logic [7:0]  RST_MAX_SPEED  = 8'd150;
  localparam logic [7:0]  RST_MIN_SPEED  = 8'd60;
  localparam logic [7:0]  RST_SPEED_HYST = 8'd5;
  localparam logic [15:0] RST_REL_LIMIT  = 16'd3840;
  localparam logic [15:0] RST_REL_HYST   = 16'd512;
  localparam logic [15:0] RST_TIME_THR   = 16'd6000;
  localparam logic [7:0]  RST_EXIT_IV    = 8'd1;
  localparam logic [9:0]  RST_CYCLE_TIME = 10'd10;

  // Turn indicator codes
  localparam logic [1:0] IND_NONE = 2'd0;
  localparam logic [1:0] IND_LEFT = 2'd1;

  localparam logic signed [7:0] NO_OBJECT = -8'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } oahc_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } oahc_cmd_t;

  typedef struct packed {
    logic div_last;
  } oahc_sts_t;

endpackage

// ===== design/overtake_assist_headway_controller.sv =====
// Overtake assist headway controller: one control tick in, one headway result out.
// An accepted tick runs the 8-step serial modulo of the release tick count by the exit
// interval, then commits; a new tick is taken only after the previous one commits, and a
// commit waits while an untaken result sits in the output register.
// A new tick is taken while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous) restores register defaults and clears all tick state.
module overtake_assist_headway_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // indicator[1:0], speedometer_kmh[9:2], ego_speed[25:10], object_speed[41:26],
  // object_id[49:42], driver_headway[65:50], zero fill[71:66]
  input  logic [oahc_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // assist_active[0], assist_active_before[1], release_pending[2],
  // headway_out[18:3], zero fill[23:19]
  output logic [oahc_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [oahc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [oahc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  oahc_pkg::oahc_cmd_t cmd;
  oahc_pkg::oahc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  oahc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  oahc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== design/oahc_datapath.sv =====
// Datapath: configuration registers, tick state, serial modulo and result register.
module oahc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oahc_pkg::oahc_cmd_t                 cmd_i,
  output oahc_pkg::oahc_sts_t                 sts_o,
  input  logic [oahc_pkg::IN_W-1:0]           in_data_i,
  input  logic                                cfg_we_i,
  input  logic [oahc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [oahc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [oahc_pkg::OUT_W-1:0]          out_data_o
);

  // Configuration registers
  logic [7:0]  max_spd_q, min_spd_q, spd_hyst_q, exit_iv_q;
  logic [15:0] rel_lim_q, rel_hyst_q, time_thr_q;
  logic [9:0]  cyc_time_q;

  // Tick state
  logic [1:0]         ind_prev_q, ind_prev_d;
  logic               armed_q, armed_d;
  logic [15:0]        time_q, time_d;
  logic [7:0]         ticks_q, ticks_d;
  logic               assist_q, assist_d;
  logic               release_q, release_d;
  logic signed [15:0] hw_q, hw_d;

  // Latched tick
  logic [1:0]         ind_q;
  logic [7:0]         spd_q;
  logic signed [15:0] ego_q, obj_q, drv_q;
  logic signed [7:0]  oid_q;

  // Serial modulo
  logic [7:0] rem_q, rem_d;
  logic [7:0] dvd_q;
  logic [7:0] dvs_q;
  logic [2:0] cnt_q;
  logic [8:0] rem_sh;
  logic [7:0] iv;

  logic [oahc_pkg::OUT_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_spd_q  <= oahc_pkg::RST_MAX_SPEED;
      min_spd_q  <= oahc_pkg::RST_MIN_SPEED;
      spd_hyst_q <= oahc_pkg::RST_SPEED_HYST;
      rel_lim_q  <= oahc_pkg::RST_REL_LIMIT;
      rel_hyst_q <= oahc_pkg::RST_REL_HYST;
      time_thr_q <= oahc_pkg::RST_TIME_THR;
      exit_iv_q  <= oahc_pkg::RST_EXIT_IV;
      cyc_time_q <= oahc_pkg::RST_CYCLE_TIME;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        oahc_pkg::CFG_MAX_SPEED:  max_spd_q  <= cfg_data_i[7:0];
        oahc_pkg::CFG_MIN_SPEED:  min_spd_q  <= cfg_data_i[7:0];
        oahc_pkg::CFG_SPEED_HYST: spd_hyst_q <= cfg_data_i[7:0];
        oahc_pkg::CFG_REL_LIMIT:  rel_lim_q  <= cfg_data_i;
        oahc_pkg::CFG_REL_HYST:   rel_hyst_q <= cfg_data_i;
        oahc_pkg::CFG_TIME_THR:   time_thr_q <= cfg_data_i;
        oahc_pkg::CFG_EXIT_IV:    exit_iv_q  <= cfg_data_i[7:0];
        oahc_pkg::CFG_CYCLE_TIME: cyc_time_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Zero interval acts as one
  assign iv = (exit_iv_q == 8'd0) ? 8'd1 : exit_iv_q;

  // Restoring remainder step, one dividend bit per cycle
  assign rem_sh = {rem_q, dvd_q[7]};
  assign rem_d  = (rem_sh >= {1'b0, dvs_q}) ? 8'(rem_sh - {1'b0, dvs_q}) : rem_sh[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (cmd_i.load) begin
      cnt_q <= 3'd0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  assign sts_o.div_last = (cnt_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ind_q <= in_data_i[1:0];
      spd_q <= in_data_i[9:2];
      ego_q <= in_data_i[25:10];
      obj_q <= in_data_i[41:26];
      oid_q <= in_data_i[49:42];
      drv_q <= in_data_i[65:50];
      rem_q <= 8'd0;
      dvd_q <= ticks_q + 8'd1;
      dvs_q <= iv;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[6:0], 1'b0};
    end
  end

  // Tick update
  logic [16:0]        t_sum;
  logic [15:0]        t_sat;
  logic signed [16:0] diff;
  logic [16:0]        rel;
  logic [16:0]        rel_off;
  logic signed [9:0]  spd_s, max_lo, min_lo;
  logic               window_ok, turn_on, turn_off, due;

  assign t_sum   = {1'b0, time_q} + {7'd0, cyc_time_q};
  assign t_sat   = t_sum[16] ? 16'hFFFF : t_sum[15:0];
  assign diff    = {ego_q[15], ego_q} - {obj_q[15], obj_q};
  assign rel     = diff[16] ? 17'(-diff) : 17'(diff);
  assign rel_off = {1'b0, rel_lim_q} + {1'b0, rel_hyst_q};
  assign spd_s   = {2'b00, spd_q};
  assign max_lo  = {2'b00, max_spd_q} - {2'b00, spd_hyst_q};
  assign min_lo  = {2'b00, min_spd_q} - {2'b00, spd_hyst_q};
  assign turn_on = (spd_q >= min_spd_q) && (spd_s < max_lo) && (rel < {1'b0, rel_lim_q});
  assign turn_off = (spd_s < min_lo) || (spd_q > max_spd_q) || (rel > rel_off);
  assign due     = (rem_q == 8'd0);

  always_comb begin
    ind_prev_d = ind_q;

    priority if (ind_q == oahc_pkg::IND_LEFT && ind_prev_q == oahc_pkg::IND_NONE) begin
      armed_d = 1'b1;
    end else if (ind_q != oahc_pkg::IND_LEFT && ind_prev_q == oahc_pkg::IND_LEFT) begin
      armed_d = 1'b0;
    end else begin
      armed_d = armed_q;
    end

    if (!armed_d) begin
      time_d = 16'd0;
    end else if (time_q < time_thr_q) begin
      time_d = t_sat;
    end else begin
      time_d = time_q;
    end

    window_ok = (time_d < time_thr_q) && armed_d && (oid_q != oahc_pkg::NO_OBJECT);
    priority if (!window_ok) begin
      assist_d = 1'b0;
    end else if (turn_on) begin
      assist_d = 1'b1;
    end else if (turn_off) begin
      assist_d = 1'b0;
    end else begin
      assist_d = assist_q;
    end

    hw_d      = hw_q;
    release_d = release_q;
    ticks_d   = ticks_q;
    priority if (assist_d) begin
      hw_d = 16'sd0;
    end else if (assist_q) begin
      release_d = 1'b1;
    end else if (release_q) begin
      ticks_d = ticks_q + 8'd1;
      priority if (hw_q < drv_q) begin
        if (due) hw_d = hw_q + 16'sd1;
      end else if (hw_q > drv_q) begin
        if (due) hw_d = hw_q - 16'sd1;
      end else begin
        release_d = 1'b0;
      end
    end else begin
      hw_d = drv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ind_prev_q <= oahc_pkg::IND_NONE;
      armed_q    <= 1'b0;
      time_q     <= 16'd0;
      ticks_q    <= 8'd0;
      assist_q   <= 1'b0;
      release_q  <= 1'b0;
      hw_q       <= 16'sd0;
    end else if (cmd_i.commit) begin
      ind_prev_q <= ind_prev_d;
      armed_q    <= armed_d;
      time_q     <= time_d;
      ticks_q    <= ticks_d;
      assist_q   <= assist_d;
      release_q  <= release_d;
      hw_q       <= hw_d;
    end
  end

  // Result beat: assist, previous assist, release, headway, zero fill
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= {5'd0, hw_d, release_d, assist_q, assist_d};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/oahc_ctrl.sv =====
// Controller: sequences accept, serial modulo, state commit and result handoff.
module oahc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  oahc_pkg::oahc_sts_t sts_i,
  output oahc_pkg::oahc_cmd_t cmd_o
);

  `include "overtake_assist_headway_controller_assert.svh"

  oahc_pkg::oahc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oahc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      oahc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = oahc_pkg::ST_DIV;
        end
      end
      oahc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = oahc_pkg::ST_COMMIT;
      end
      oahc_pkg::ST_COMMIT: begin
        // hold until the result register can take the new beat
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = oahc_pkg::ST_IDLE;
        end
      end
      default: state_d = oahc_pkg::ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  `OAHC_ASSERT(a_accept_starts_div, (in_valid_i && in_ready_o) |=> (state_q == oahc_pkg::ST_DIV),
               "accepted beat did not start the modulo")
  `OAHC_ASSERT(a_div_ends, (state_q == oahc_pkg::ST_DIV && sts_i.div_last) |=>
               (state_q == oahc_pkg::ST_COMMIT), "modulo did not end after eight steps")
  `OAHC_ASSERT(a_no_overwrite, cmd_o.commit |-> (!out_valid_q || out_ready_i),
               "commit overwrote an untaken result")
  `OAHC_ASSERT(a_commit_shows, cmd_o.commit |=> out_valid_q,
               "committed result not presented")

endmodule

// ===== sim/tb_overtake_assist_headway_controller.sv =====
// Testbench for the overtake assist headway controller: scripted and random ticks vs predictor.
module tb_overtake_assist_headway_controller;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TICKS_PER_PHASE = 215;
  localparam int TIMER_MAX = 65535;
  localparam logic [1:0] IND_RIGHT = 2'd2;
  localparam logic [1:0] IND_OTHER = 2'd3;
  localparam logic [oahc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [oahc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [1:0]         ind;
    logic [7:0]         spd;
    logic signed [15:0] ego;
    logic signed [15:0] obj;
    logic signed [7:0]  oid;
    logic signed [15:0] drv;
  } tick_t;

  typedef struct packed {
    logic               active;
    logic               prev_active;
    logic               release_on;
    logic signed [15:0] hw;
  } headway_res_t;

  typedef struct packed {
    tick_t        t;
    logic         typed;
    headway_res_t e;
  } script_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [oahc_pkg::IN_W-1:0]       s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [oahc_pkg::OUT_W-1:0]      m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [oahc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [oahc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  overtake_assist_headway_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor registers and state
  int cfg_max = oahc_pkg::RST_MAX_SPEED;
  int cfg_min = oahc_pkg::RST_MIN_SPEED;
  int cfg_hyst = oahc_pkg::RST_SPEED_HYST;
  int cfg_rel_lim = oahc_pkg::RST_REL_LIMIT;
  int cfg_rel_hyst = oahc_pkg::RST_REL_HYST;
  int cfg_time_thr = oahc_pkg::RST_TIME_THR;
  int cfg_exit_iv = oahc_pkg::RST_EXIT_IV;
  int cfg_cycle = oahc_pkg::RST_CYCLE_TIME;

  logic [1:0] ind_prev = oahc_pkg::IND_NONE;
  bit         left_armed = 1'b0;
  int         timer_ms = 0;
  int         exit_cnt = 0;
  bit         assist_on = 1'b0;
  bit         release_on = 1'b0;
  int         headway_lvl = 0;

  headway_res_t headway_q [$];
  headway_res_t want_res, got_res;
  int errors = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 86;

  script_row_t                    script [24];
  logic [15:0]                    reg_vals [8];
  logic [oahc_pkg::CFG_IDX_W-1:0] reg_order [8] = '{
    oahc_pkg::CFG_MAX_SPEED, oahc_pkg::CFG_MIN_SPEED, oahc_pkg::CFG_SPEED_HYST,
    oahc_pkg::CFG_REL_LIMIT, oahc_pkg::CFG_REL_HYST, oahc_pkg::CFG_TIME_THR,
    oahc_pkg::CFG_EXIT_IV, oahc_pkg::CFG_CYCLE_TIME};

  function automatic headway_res_t predict_headway(input tick_t t);
    headway_res_t r;
    int rel;
    int spd;
    int iv;
    bit due;
    r.prev_active = assist_on;
    spd = int'(t.spd);
    if (t.ind == oahc_pkg::IND_LEFT && ind_prev == oahc_pkg::IND_NONE) begin
      left_armed = 1'b1;
    end else if (t.ind != oahc_pkg::IND_LEFT && ind_prev == oahc_pkg::IND_LEFT) begin
      left_armed = 1'b0;
    end
    if (left_armed) begin
      if (timer_ms < cfg_time_thr) begin
        timer_ms = (timer_ms + cfg_cycle > TIMER_MAX) ? TIMER_MAX : timer_ms + cfg_cycle;
      end
    end else begin
      timer_ms = 0;
    end
    if (timer_ms < cfg_time_thr && left_armed && t.oid != oahc_pkg::NO_OBJECT) begin
      rel = int'(t.ego) - int'(t.obj);
      if (rel < 0) rel = -rel;
      if (spd >= cfg_min && spd < cfg_max - cfg_hyst && rel < cfg_rel_lim) begin
        assist_on = 1'b1;
      end else if (spd < cfg_min - cfg_hyst || spd > cfg_max ||
                   rel > cfg_rel_lim + cfg_rel_hyst) begin
        assist_on = 1'b0;
      end
    end else begin
      assist_on = 1'b0;
    end
    if (assist_on) begin
      headway_lvl = 0;
    end else if (r.prev_active) begin
      release_on = 1'b1;
    end else if (release_on) begin
      iv = (cfg_exit_iv == 0) ? 1 : cfg_exit_iv;
      exit_cnt = (exit_cnt + 1) % 256;
      due = (exit_cnt % iv) == 0;
      if (headway_lvl < int'(t.drv)) begin
        if (due) headway_lvl++;
      end else if (headway_lvl > int'(t.drv)) begin
        if (due) headway_lvl--;
      end else begin
        release_on = 1'b0;
      end
    end else begin
      headway_lvl = int'(t.drv);
    end
    ind_prev = t.ind;
    r.active = assist_on;
    r.release_on = release_on;
    r.hw = 16'(headway_lvl);
    return r;
  endfunction

  function automatic void store_reg(input logic [oahc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] data);
    case (idx)
      oahc_pkg::CFG_MAX_SPEED:  cfg_max = int'(data[7:0]);
      oahc_pkg::CFG_MIN_SPEED:  cfg_min = int'(data[7:0]);
      oahc_pkg::CFG_SPEED_HYST: cfg_hyst = int'(data[7:0]);
      oahc_pkg::CFG_REL_LIMIT:  cfg_rel_lim = int'(data);
      oahc_pkg::CFG_REL_HYST:   cfg_rel_hyst = int'(data);
      oahc_pkg::CFG_TIME_THR:   cfg_time_thr = int'(data);
      oahc_pkg::CFG_EXIT_IV:    cfg_exit_iv = int'(data[7:0]);
      oahc_pkg::CFG_CYCLE_TIME: cfg_cycle = int'(data[9:0]);
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: random stalls and in-order comparison
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.active = m_axis_tdata[0];
      got_res.prev_active = m_axis_tdata[1];
      got_res.release_on = m_axis_tdata[2];
      got_res.hw = m_axis_tdata[18:3];
      if (headway_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_res = headway_q.pop_front();
        check_field("assist_active", want_res.active, got_res.active);
        check_field("assist_active_before", want_res.prev_active, got_res.prev_active);
        check_field("release_pending", want_res.release_on, got_res.release_on);
        check_field("headway_out", int'(want_res.hw), int'(got_res.hw));
      end
    end
  end

  task automatic send_tick(input tick_t t, input logic typed, input headway_res_t typed_res);
    headway_res_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, t.drv, t.oid, t.obj, t.ego, t.spd, t.ind};
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_headway(t);
    headway_q.push_back(typed ? typed_res : p);
  endtask

  task automatic drain();
    while (headway_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [oahc_pkg::CFG_IDX_W-1:0] spare_idx);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_order[i];
      cfg_data_i <= reg_vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      store_reg(reg_order[i], reg_vals[i]);
    end
    // an index past the register map must change nothing
    cfg_index_i <= spare_idx;
    cfg_data_i <= 16'($urandom);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_phase(input int p);
    case (p)
      0: begin
        reg_vals[0] = 16'hA596;
        reg_vals[1] = 16'h5A3C;
        reg_vals[2] = 16'h0005;
        reg_vals[3] = 16'd3840;
        reg_vals[4] = 16'd512;
        reg_vals[5] = 16'($urandom_range(100, 800));
        reg_vals[6] = 16'hFF00;  // interval of zero
        reg_vals[7] = 16'd10;
      end
      1: begin
        reg_vals[0] = 16'h00FF;
        reg_vals[1] = 16'h0000;
        reg_vals[2] = 16'h0000;
        reg_vals[3] = 16'hFFFF;
        reg_vals[4] = 16'hFFFF;
        reg_vals[5] = 16'hFFFF;  // timer saturates at this threshold
        reg_vals[6] = 16'h00FF;
        reg_vals[7] = 16'hFFE8;
      end
      2: begin
        foreach (reg_vals[i]) reg_vals[i] = 16'h0000;
      end
      default: begin
        reg_vals[0] = {8'($urandom), 8'($urandom_range(60, 255))};
        reg_vals[1] = {8'($urandom), 8'($urandom_range(0, 120))};
        reg_vals[2] = {8'($urandom), 8'($urandom_range(0, 20))};
        reg_vals[3] = 16'($urandom_range(0, 8000));
        reg_vals[4] = 16'($urandom_range(0, 2000));
        reg_vals[5] = 16'($urandom_range(0, 4000));
        reg_vals[6] = (p == 5) ? {8'($urandom), 8'($urandom_range(100, 255))}
                               : {8'($urandom), 8'($urandom_range(0, 12))};
        reg_vals[7] = {6'($urandom), 10'($urandom_range(0, 120))};
      end
    endcase
    write_regs(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO);
  endtask

  function automatic logic signed [15:0] pick_headway();
    case ($urandom_range(0, 19))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 40)) - 16'sd20;
    endcase
  endfunction

  function automatic tick_t shaped_tick(input logic [1:0] ind, input logic signed [15:0] drv);
    tick_t t;
    int lo, hi, ego, d;
    t.ind = ind;
    t.drv = drv;
    lo = cfg_min;
    hi = cfg_max - cfg_hyst - 1;
    case ($urandom_range(0, 7))
      0: t.spd = 8'($urandom);
      1: t.spd = 8'(cfg_max + int'($urandom_range(0, 2)) - 1);
      2: t.spd = 8'(cfg_min - cfg_hyst + int'($urandom_range(0, 2)) - 1);
      default: t.spd = (hi >= lo) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
    endcase
    ego = int'($urandom_range(0, 20000)) - 10000;
    case ($urandom_range(0, 5))
      0: d = int'($urandom_range(0, 20000));
      1: d = cfg_rel_lim + cfg_rel_hyst + int'($urandom_range(0, 2)) - 1;
      default: d = (cfg_rel_lim > 0) ? int'($urandom_range(0, cfg_rel_lim - 1)) : 0;
    endcase
    if (d > 20000) d = 20000;
    if ($urandom_range(0, 1)) d = -d;
    t.ego = 16'(ego);
    t.obj = 16'(ego - d);
    t.oid = ($urandom_range(0, 11) == 0) ? oahc_pkg::NO_OBJECT : 8'($urandom);
    return t;
  endfunction

  task automatic feed_tick(input tick_t t, inout int n);
    logic [95:0] raw;
    // replace some ticks with raw noise
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom};
      t = raw[65:0];
      if ($urandom_range(0, 3) == 0) t.oid = oahc_pkg::NO_OBJECT;
    end
    send_tick(t, 1'b0, '0);
    n++;
  endtask

  // one overtake: indicator idle, left run, then exit with release toward the driver level
  task automatic run_overtake(inout int n);
    logic signed [15:0] drv;
    logic [1:0] ind;
    int lead, len, tail;
    drv = pick_headway();
    lead = $urandom_range(1, 3);
    for (int i = 0; i < lead; i++) begin
      ind = (i == lead - 1) ? oahc_pkg::IND_NONE : 2'($urandom_range(0, 3));
      feed_tick(shaped_tick(ind, drv), n);
    end
    len = $urandom_range(1, 90);
    for (int i = 0; i < len; i++) feed_tick(shaped_tick(oahc_pkg::IND_LEFT, drv), n);
    case ($urandom_range(0, 2))
      0: ind = oahc_pkg::IND_NONE;
      1: ind = IND_RIGHT;
      default: ind = IND_OTHER;
    endcase
    tail = $urandom_range(1, 40);
    for (int i = 0; i < tail; i++) begin
      if ($urandom_range(0, 9) == 0) drv = pick_headway();
      feed_tick(shaped_tick(ind, drv), n);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int n;
    script = '{
      '{'{oahc_pkg::IND_NONE, 8'd0, 16'sd0, 16'sd0, oahc_pkg::NO_OBJECT, 16'sd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 16'sd0}},
      '{'{IND_OTHER, 8'd255, 16'sh7FFF, 16'sh8000, 8'sh7F, 16'sh7FFF}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 16'sh7FFF}},
      '{'{IND_RIGHT, 8'd0, 16'sh8000, 16'sh7FFF, 8'sh80, 16'sh8000}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 16'sh8000}},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, 16'sd3}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 16'sd3}},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd256, 16'sd256, 8'sd5, 16'sd3}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 16'sd0}},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd256, 16'sd256, 8'sd5, 16'sd3}, 1'b1,
        '{1'b1, 1'b1, 1'b0, 16'sd0}},
      // hold inside the upper speed band, then drop above the limit
      '{'{oahc_pkg::IND_LEFT, 8'd145, 16'sd256, 16'sd256, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd151, 16'sd256, 16'sd256, 8'sd5, 16'sd3}, 1'b0, '0},
      // assist resumes during release
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd256, 16'sd256, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd4352, 16'sd0, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd4353, 16'sd0, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd256, 16'sd256, oahc_pkg::NO_OBJECT, 16'sd3},
        1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, 16'sd3}, 1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd60, 16'sh8000, 16'sh7FFF, 8'sd0, -16'sd2}, 1'b0, '0},
      // left straight from right must not arm
      '{'{IND_RIGHT, 8'd100, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd100, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd60, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd59, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_LEFT, 8'd54, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0},
      '{'{oahc_pkg::IND_NONE, 8'd100, 16'sd0, 16'sd0, 8'sd5, -16'sd2}, 1'b0, '0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (script[i]) send_tick(script[i].t, script[i].typed, script[i].e);
    s_axis_tvalid <= 1'b0;
    drain();
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 7;  recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      program_phase(p);
      n = 0;
      while (n < TICKS_PER_PHASE) run_overtake(n);
      s_axis_tvalid <= 1'b0;
      drain();
    end
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
